@@ hdl/assert_macros.svh @@
// -----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers included by the FIFO core.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check prop on every rising clock edge outside reset
`define ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");

// Check that ante implies cons in the same cycle
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("implication failed");

`else

`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons)

`endif

`endif

@@ hdl/brf_pkg.sv @@
// -----------------------------------------------------------------------------
// brf_pkg
// Types and constants of the byte ring FIFO with block-granular reads.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

package brf_pkg;

    // Default sizes
    localparam int BRF_DEPTH    = 65536;
    localparam int BRF_MAX_READ = 64;

    // Field widths
    localparam int FUNC_W = 2;
    localparam int LEN_W  = 16;
    localparam int BYTE_W = 8;
    localparam int BLK_W  = 7;
    localparam int STAT_W = 3;
    localparam int CNT_W  = 16;

    // Item function codes
    typedef enum logic [FUNC_W-1:0] {
        FN_CLEAR = 2'd0,
        FN_OPEN  = 2'd1,
        FN_WRITE = 2'd2,
        FN_READ  = 2'd3
    } t_func;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_CLEARED  = 3'd0,
        ST_WR_OK    = 3'd1,
        ST_WR_REFUS = 3'd2,
        ST_RD_EMPTY = 3'd3,
        ST_RD_REFUS = 3'd4,
        ST_RD_DATA  = 3'd5
    } t_status;

    // Control sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_READ
    } t_state;

    // Remainder unit response
    typedef struct packed {
        logic             done;
        logic [BLK_W-1:0] rem;
    } t_rem_rsp;

endpackage

@@ hdl/brf_ram.sv @@
// -----------------------------------------------------------------------------
// brf_ram
// Byte store: one write port, one read port, registered read data.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module brf_ram #(
    parameter int DEPTH = brf_pkg::BRF_DEPTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [AW-1:0]             i_waddr,
    input  logic [brf_pkg::BYTE_W-1:0] i_wdata,
    input  logic                      i_re,
    input  logic [AW-1:0]             i_raddr,
    output logic [brf_pkg::BYTE_W-1:0] o_rdata
);

    logic [brf_pkg::BYTE_W-1:0] r_mem [DEPTH];
    logic [brf_pkg::BYTE_W-1:0] r_rdata;

    // Store one byte
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Fetch one byte, hold it until the next fetch
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/brf_rem.sv @@
// -----------------------------------------------------------------------------
// brf_rem
// Restoring remainder unit, one dividend bit per cycle.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module brf_rem #(
    parameter int N_BITS = 7
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [N_BITS-1:0]         i_dividend,
    input  logic [brf_pkg::BLK_W-1:0] i_divisor,
    output brf_pkg::t_rem_rsp         o_rsp
);

    localparam int CW = $clog2(N_BITS + 1);

    logic                      r_busy;
    logic                      r_done;
    logic [CW-1:0]             r_cnt;
    logic [N_BITS-1:0]         r_sh;
    logic [brf_pkg::BLK_W-1:0] r_rem;
    logic [brf_pkg::BLK_W:0]   trial;
    logic [brf_pkg::BLK_W:0]   n_part;

    // Shift in the next dividend bit and subtract when it fits
    always_comb begin
        trial  = {r_rem, r_sh[N_BITS-1]};
        n_part = (trial >= {1'b0, i_divisor}) ? (trial - {1'b0, i_divisor}) : trial;
    end

    // Sequence the iterations
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(N_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Partial remainder and dividend shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sh  <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_sh  <= r_sh << 1;
            r_rem <= n_part[brf_pkg::BLK_W-1:0];
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

endmodule

@@ hdl/byte_ring_fifo_block_read_core.sv @@
// -----------------------------------------------------------------------------
// byte_ring_fifo_block_read_core
// Byte ring FIFO holding DEPTH-1 bytes, all-or-nothing writes, reads of up
// to MAX_READ bytes, a short read trimmed to whole blocks.
// -----------------------------------------------------------------------------
//  channel   handshake            payload
//  input     i_valid / o_ready    i_func i_write_length i_in_byte i_read_length
//                                 i_block i_must_exact
//  output    o_valid / i_ready    o_status o_out_byte o_granted o_last
//                                 o_free_space o_used_count
//
//  Clear, open, write-byte and non-data reads finish when accepted.
//  A data read of N bytes fetches each byte into the store read register,
//  then moves it to the output, one byte per cycle unless the output stalls.
//  A trimmed read first runs the remainder unit over N_BITS dividend bits,
//  where N_BITS = clog2(MAX_READ+1).
//  Reset clears pointers and counts; store contents stay unspecified.
//  A stalled output holds the read sequencer and the input.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module byte_ring_fifo_block_read_core #(
    parameter int DEPTH    = brf_pkg::BRF_DEPTH,
    parameter int MAX_READ = brf_pkg::BRF_MAX_READ
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [brf_pkg::FUNC_W-1:0] i_func,
    input  logic [brf_pkg::LEN_W-1:0]  i_write_length,
    input  logic [brf_pkg::BYTE_W-1:0] i_in_byte,
    input  logic [brf_pkg::BLK_W-1:0]  i_read_length,
    input  logic [brf_pkg::BLK_W-1:0]  i_block,
    input  logic                       i_must_exact,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [brf_pkg::STAT_W-1:0] o_status,
    output logic [brf_pkg::BYTE_W-1:0] o_out_byte,
    output logic [brf_pkg::BLK_W-1:0]  o_granted,
    output logic                       o_last,
    output logic [brf_pkg::CNT_W-1:0]  o_free_space,
    output logic [brf_pkg::CNT_W-1:0]  o_used_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int RW = $clog2(MAX_READ + 1);
    localparam int CW = (AW > brf_pkg::CNT_W) ? AW : brf_pkg::CNT_W;

    brf_pkg::t_state r_state;
    brf_pkg::t_state n_state;
    brf_pkg::t_func  func;

    logic [AW-1:0]               r_wptr;
    logic [AW-1:0]               r_rptr;
    logic [AW-1:0]               r_used;
    logic [brf_pkg::LEN_W-1:0]   r_pend;
    logic [RW-1:0]               r_issue;
    logic [RW-1:0]               r_left;
    logic [RW-1:0]               r_grant;
    logic [RW-1:0]               r_stored;
    logic [brf_pkg::BLK_W-1:0]   r_gran;
    logic                        r_dv;

    logic                        r_ov;
    brf_pkg::t_status            r_status;
    logic [brf_pkg::BYTE_W-1:0]  r_byte;
    logic [brf_pkg::BLK_W-1:0]   r_granted;
    logic                        r_last;
    logic [brf_pkg::CNT_W-1:0]   r_free;
    logic [brf_pkg::CNT_W-1:0]   r_usedo;

    logic                        acc;
    logic [AW-1:0]               free_cnt;
    logic [CW-1:0]               used_c;
    logic [CW-1:0]               free_c;
    logic [brf_pkg::BLK_W-1:0]   rlen_sat;
    logic [brf_pkg::BLK_W-1:0]   gran;
    logic                        is_empty;
    logic                        is_short;
    logic                        refuse;
    logic                        zero_rd;
    logic                        open_refuse;
    logic [RW-1:0]               trimmed;
    logic [RW-1:0]               want_v;
    logic                        move;
    logic                        rd_issue;
    logic                        rem_start;
    logic                        start_read;
    logic                        wr_en;
    logic                        load_res;
    brf_pkg::t_status            res_status;
    logic [AW-1:0]               res_used;
    logic [CW-1:0]               res_used_c;
    logic [CW-1:0]               res_free_c;
    logic [brf_pkg::BYTE_W-1:0]  rd_data;
    brf_pkg::t_rem_rsp           rem_rsp;

    // Decode the offered item against the current fill level
    always_comb begin
        func        = brf_pkg::t_func'(i_func);
        acc         = i_valid && o_ready;
        free_cnt    = AW'(DEPTH - 1) - r_used;
        used_c      = CW'(r_used);
        free_c      = CW'(free_cnt);
        rlen_sat    = (i_read_length > brf_pkg::BLK_W'(MAX_READ)) ?
                      brf_pkg::BLK_W'(MAX_READ) : i_read_length;
        gran        = (i_block == '0) ? brf_pkg::BLK_W'(1) : i_block;
        is_empty    = (r_used == '0);
        is_short    = CW'(rlen_sat) > used_c;
        refuse      = is_short && (i_must_exact || (used_c < CW'(gran)));
        zero_rd     = !is_short && (rlen_sat == '0);
        open_refuse = free_c < CW'(i_write_length);
        trimmed     = r_stored - RW'(rem_rsp.rem);
        want_v      = (r_state == brf_pkg::S_DIV) ? trimmed : RW'(rlen_sat);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            brf_pkg::S_IDLE: begin
                if (acc && func == brf_pkg::FN_READ && !is_empty && !refuse) begin
                    if (is_short) begin
                        n_state = brf_pkg::S_DIV;
                    end else if (!zero_rd) begin
                        n_state = brf_pkg::S_READ;
                    end
                end
            end
            brf_pkg::S_DIV: begin
                if (rem_rsp.done) begin
                    n_state = brf_pkg::S_READ;
                end
            end
            brf_pkg::S_READ: begin
                if (move && r_left == RW'(1)) begin
                    n_state = brf_pkg::S_IDLE;
                end
            end
            default: n_state = brf_pkg::S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        o_ready    = (r_state == brf_pkg::S_IDLE) && (!r_ov || i_ready);
        move       = (r_state == brf_pkg::S_READ) && r_dv && (!r_ov || i_ready);
        rd_issue   = (r_state == brf_pkg::S_READ) && (r_issue != '0) && (!r_dv || move);
        rem_start  = acc && func == brf_pkg::FN_READ && !is_empty && !refuse && is_short;
        start_read = ((r_state == brf_pkg::S_DIV) && rem_rsp.done) ||
                     (acc && func == brf_pkg::FN_READ && !is_empty && !is_short
                      && !zero_rd);
        wr_en      = acc && func == brf_pkg::FN_WRITE && (r_pend != '0)
                     && (free_cnt != '0);
        load_res   = acc && func != brf_pkg::FN_WRITE && !rem_start && !start_read;
        unique case (func)
            brf_pkg::FN_CLEAR: res_status = brf_pkg::ST_CLEARED;
            brf_pkg::FN_OPEN:  res_status = open_refuse ? brf_pkg::ST_WR_REFUS :
                                                          brf_pkg::ST_WR_OK;
            brf_pkg::FN_READ: begin
                if (is_empty) begin
                    res_status = brf_pkg::ST_RD_EMPTY;
                end else if (refuse) begin
                    res_status = brf_pkg::ST_RD_REFUS;
                end else begin
                    res_status = brf_pkg::ST_RD_DATA;
                end
            end
            default: res_status = brf_pkg::ST_CLEARED;
        endcase
        res_used   = (func == brf_pkg::FN_CLEAR) ? '0 : r_used;
        res_used_c = CW'(res_used);
        res_free_c = CW'(AW'(DEPTH - 1) - res_used);
    end

    // Control state, pointers and counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= brf_pkg::S_IDLE;
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_used  <= '0;
            r_pend  <= '0;
            r_issue <= '0;
            r_left  <= '0;
            r_dv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;

            // Clear empties the ring; open arms or drops the write
            if (acc && func == brf_pkg::FN_CLEAR) begin
                r_wptr <= '0;
                r_rptr <= '0;
                r_used <= '0;
                r_pend <= '0;
            end else if (acc && func == brf_pkg::FN_OPEN) begin
                r_pend <= open_refuse ? '0 : i_write_length;
            end else if (wr_en) begin
                r_wptr <= (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
                r_used <= r_used + 1'b1;
                r_pend <= r_pend - 1'b1;
            end else if (start_read) begin
                r_used <= r_used - AW'(want_v);
            end

            // Arm the read sequencer
            if (start_read) begin
                r_issue <= want_v;
                r_left  <= want_v;
            end

            // Advance the read pointer per fetch
            if (rd_issue) begin
                r_rptr  <= (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
                r_issue <= r_issue - 1'b1;
            end

            // Track the fetched byte not yet moved to the output
            if (rd_issue) begin
                r_dv <= 1'b1;
            end else if (move) begin
                r_dv <= 1'b0;
            end

            if (move) begin
                r_left <= r_left - 1'b1;
            end

            // Output register occupancy
            if (load_res || move) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (rem_start) begin
            r_stored <= RW'(r_used);
            r_gran   <= gran;
        end
        if (start_read) begin
            r_grant <= want_v;
        end
        if (load_res) begin
            r_status  <= res_status;
            r_byte    <= '0;
            r_granted <= '0;
            r_last    <= 1'b1;
            r_free    <= res_free_c[brf_pkg::CNT_W-1:0];
            r_usedo   <= res_used_c[brf_pkg::CNT_W-1:0];
        end else if (move) begin
            r_status  <= brf_pkg::ST_RD_DATA;
            r_byte    <= rd_data;
            r_granted <= brf_pkg::BLK_W'(r_grant);
            r_last    <= (r_left == RW'(1));
            r_free    <= free_c[brf_pkg::CNT_W-1:0];
            r_usedo   <= used_c[brf_pkg::CNT_W-1:0];
        end
    end

    brf_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_wptr),
        .i_wdata (i_in_byte),
        .i_re    (rd_issue),
        .i_raddr (r_rptr),
        .o_rdata (rd_data)
    );

    brf_rem #(
        .N_BITS (RW)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (rem_start),
        .i_dividend (RW'(r_used)),
        .i_divisor  (r_gran),
        .o_rsp      (rem_rsp)
    );

    assign o_valid      = r_ov;
    assign o_status     = r_status;
    assign o_out_byte   = r_byte;
    assign o_granted    = r_granted;
    assign o_last       = r_last;
    assign o_free_space = r_free;
    assign o_used_count = r_usedo;

    // Unfetched plus fetched-but-unmoved bytes match the remaining beats during a read
    `ASSERT_IMPL(a_read_balance, i_clk, i_rst_n, r_state == brf_pkg::S_READ, r_left == (r_issue + RW'(r_dv)))
    // Remainder completes only while the sequencer waits for it
    `ASSERT_IMPL(a_rem_in_div, i_clk, i_rst_n, rem_rsp.done, r_state == brf_pkg::S_DIV)
    // Input is taken only when the output slot frees up
    `ASSERT_IMPL(a_in_slot, i_clk, i_rst_n, o_ready, !o_valid || i_ready)
    // Fill level stays below the ring size
    `ASSERT_CLK(a_fill_bound, i_clk, i_rst_n, CW'(r_used) <= CW'(DEPTH - 1))

endmodule
